/* hdl/ncss_pkg.sv */
// ----------------------------------------------------------------------------
// ncss_pkg
// Shared types and constants for the nearest charging station search block.
// ----------------------------------------------------------------------------
package ncss_pkg;

  // Matrix geometry and distance format (unsigned 16.8 fixed point).
  localparam int MaxNodes  = 128;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int CountW    = NodeW + 1;
  localparam int DistW     = 24;
  localparam int SumW      = DistW + 1;
  localparam int AddrW     = 2 * NodeW;
  localparam int StoreSize = MaxNodes * MaxNodes;

  // Configuration register widths.
  localparam int CustW    = 7;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = DistW;

  // Input item operation codes.
  localparam int FuncW = 2;
  typedef enum logic [FuncW-1:0] {
    FUNC_WRITE    = 2'd0,
    FUNC_BEST     = 2'd1,
    FUNC_FEASIBLE = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CUSTOMER_COUNT = 2'd0,
    CFG_NODE_COUNT     = 2'd1,
    CFG_CRUISE_RANGE   = 2'd2,
    CFG_UNUSED         = 2'd3
  } cfg_idx_e;

endpackage

/* hdl/nearest_charging_station_search.sv */
// ----------------------------------------------------------------------------
// nearest_charging_station_search
// Distance matrix store with a least-detour charging station search.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid_i / in_stall_o) carries one transaction per
// item. A write item (func 0) stores distance_value_i at row_index_i,
// col_index_i and produces no result. A query (func 1 best,
// func 2 feasible) scans the station nodes customer_count + 1 ..
// min(node_count, 128) - 1 and returns one result on the output channel
// (out_valid_o / out_stall_i).
// The scan is paced by the two read ports of the distance memory: each
// station needs three reads, so each station takes a phase 0 and a phase 1.
// A query passes through the scan and the emit state before its result
// reaches the output register.
// func 3 is accepted and dropped.
// While a query runs the input is stalled. A finished result sits in the
// output register; the next item is accepted while it waits, and a further
// query holds its result back until the receiver takes the previous one.
// Reset clears the control state and returns the configuration registers to
// their defaults; the distance memory is not cleared and must be written
// before it is read.
// ----------------------------------------------------------------------------
module nearest_charging_station_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write port
  input  logic                            cfg_we_i,
  input  logic [ncss_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ncss_pkg::CfgDataW-1:0]   cfg_wdata_i,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ncss_pkg::FuncW-1:0]      func_i,
  input  logic [ncss_pkg::NodeW-1:0]      row_index_i,
  input  logic [ncss_pkg::NodeW-1:0]      col_index_i,
  input  logic [ncss_pkg::DistW-1:0]      distance_value_i,
  input  logic [ncss_pkg::NodeW-1:0]      from_node_i,
  input  logic [ncss_pkg::NodeW-1:0]      to_node_i,
  input  logic [ncss_pkg::DistW-1:0]      reach_limit_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [ncss_pkg::NodeW-1:0]      station_o
);

  import ncss_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e              state_q;
  logic                phase_q;
  logic [CountW-1:0]   stn_q;
  logic [NodeW-1:0]    from_q;
  logic [NodeW-1:0]    to_q;
  logic [DistW-1:0]    reach_q;
  logic                feas_q;
  logic                cand_q;
  logic                reach_ok_q;
  logic [SumW-1:0]     sum_q;
  logic                have_q;
  logic [NodeW-1:0]    best_q;
  logic [SumW-1:0]     best_sum_q;
  logic                out_valid_q;
  logic                found_q;
  logic [NodeW-1:0]    station_q;

  logic [CustW-1:0]    cust_q;
  logic [CountW-1:0]   nodes_q;
  logic [DistW-1:0]    cruise_q;

  logic                in_acc;
  logic                mem_we;
  logic [AddrW-1:0]    raddr_a;
  logic [AddrW-1:0]    raddr_b;
  logic [DistW-1:0]    rdata_a;
  logic [DistW-1:0]    rdata_b;
  logic [CountW-1:0]   scan_end;
  logic [CountW-1:0]   scan_start;
  logic                stn_ok_d;
  logic                take_d;
  logic                emit_go;

  assign in_acc = in_valid_i && !in_stall_o;
  assign mem_we = in_acc && (func_i == FUNC_WRITE);

  // The scan stops at the lesser of the node count and the matrix size.
  assign scan_end   = (nodes_q < CountW'(MaxNodes)) ? nodes_q : CountW'(MaxNodes);
  assign scan_start = CountW'(cust_q) + CountW'(1);

  // Phase 0 reads d[from][s] and d[to][s]; phase 1 reads d[s][to].
  assign raddr_a = phase_q ? {stn_q[NodeW-1:0], to_q} : {from_q, stn_q[NodeW-1:0]};
  assign raddr_b = {to_q, stn_q[NodeW-1:0]};

  ncss_ram #(
    .Width(DistW),
    .Depth(StoreSize)
  ) u_dist_ram (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   ({row_index_i, col_index_i}),
    .wdata_i   (distance_value_i),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // In phase 0 the port A data is d[s][to] of the station staged last; that
  // completes the feasibility test and the running minimum is updated.
  assign stn_ok_d = cand_q && (!feas_q || (reach_ok_q && (rdata_a < cruise_q)));
  assign take_d   = stn_ok_d && (!have_q || (sum_q < best_sum_q));

  // A finished search loads the output register once it is free.
  assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cust_q   <= '0;
      nodes_q  <= '0;
      cruise_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_CUSTOMER_COUNT: cust_q   <= cfg_wdata_i[CustW-1:0];
        CFG_NODE_COUNT:     nodes_q  <= cfg_wdata_i[CountW-1:0];
        CFG_CRUISE_RANGE:   cruise_q <= cfg_wdata_i[DistW-1:0];
        default: ;
      endcase
    end
  end

  // Search sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= 1'b0;
      stn_q       <= '0;
      from_q      <= '0;
      to_q        <= '0;
      reach_q     <= '0;
      feas_q      <= 1'b0;
      cand_q      <= 1'b0;
      reach_ok_q  <= 1'b0;
      sum_q       <= '0;
      have_q      <= 1'b0;
      best_q      <= '0;
      best_sum_q  <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      station_q   <= '0;
    end else begin
      // The receiver takes the waiting result and no new one replaces it.
      if (out_valid_q && !out_stall_i && !emit_go) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && ((func_i == FUNC_BEST) || (func_i == FUNC_FEASIBLE))) begin
            state_q <= ST_SCAN;
            phase_q <= 1'b0;
            stn_q   <= scan_start;
            from_q  <= from_node_i;
            to_q    <= to_node_i;
            reach_q <= reach_limit_i;
            feas_q  <= (func_i == FUNC_FEASIBLE);
            cand_q  <= 1'b0;
            have_q  <= 1'b0;
          end
        end

        ST_SCAN: begin
          if (!phase_q) begin
            // Retire the staged station, then issue the next one or stop.
            // The staged station index is one below the counter in phase 0.
            if (take_d) begin
              have_q     <= 1'b1;
              best_q     <= NodeW'(stn_q - CountW'(1));
              best_sum_q <= sum_q;
            end
            cand_q <= 1'b0;
            if (stn_q < scan_end) begin
              phase_q <= 1'b1;
            end else begin
              state_q <= ST_EMIT;
            end
          end else begin
            // Stage this station's detour and reach test.
            cand_q     <= (stn_q[NodeW-1:0] != from_q) && (stn_q[NodeW-1:0] != to_q);
            reach_ok_q <= rdata_a < reach_q;
            sum_q      <= SumW'(rdata_a) + SumW'(rdata_b);
            stn_q      <= stn_q + CountW'(1);
            phase_q    <= 1'b0;
          end
        end

        ST_EMIT: begin
          if (emit_go) begin
            out_valid_q <= 1'b1;
            found_q     <= have_q;
            station_q   <= have_q ? best_q : '0;
            state_q     <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign station_o   = station_q;

endmodule

/* hdl/ncss_ram.sv */
// ----------------------------------------------------------------------------
// ncss_ram
// Generic RAM with one write port and two read ports, registered read data.
// ----------------------------------------------------------------------------
module ncss_ram #(
  parameter int Width = 24,
  parameter int Depth = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  // Write port and both registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

/* hdl/ncss_checker.sv */
// ----------------------------------------------------------------------------
// ncss_checker
// Port-level checks for the nearest charging station search block.
// ----------------------------------------------------------------------------
module ncss_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [ncss_pkg::FuncW-1:0]      func_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            found_o,
  input logic [ncss_pkg::NodeW-1:0]      station_o
);

  import ncss_pkg::*;

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A result without a station reports station zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> station_o == '0)
    else $error("station not zero when nothing found");

  // Stations start above the depot, so a found station is never node zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> station_o != '0)
    else $error("found station is the depot");

  // An accepted query occupies the block in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && ((func_i == FUNC_BEST) || (func_i == FUNC_FEASIBLE))
    |=> in_stall_o)
    else $error("query did not start a scan");

  // A write transaction produces no result in the next cycle by itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o && in_valid_i && !in_stall_o && (func_i == FUNC_WRITE)
    |=> !out_valid_o)
    else $error("write produced a result");

endmodule

bind nearest_charging_station_search ncss_checker u_ncss_checker (.*);
